FILE: rtl/fwt_pkg.sv
// fwt_pkg: shared widths, operation codes and limits of the futex wait table
// no dependencies
package fwt_pkg;

    localparam int KindW   = 2;
    localparam int AddrW   = 64;
    localparam int ThreadW = 8;
    localparam int CountW  = 6;

    // most threads released by one wake or requeue
    localparam logic [CountW-1:0] MaxResults = CountW'(32);

    typedef enum logic [KindW-1:0] {
        KIND_WAIT    = 2'd0,
        KIND_WAKE    = 2'd1,
        KIND_REQUEUE = 2'd2,
        KIND_CLEAR   = 2'd3
    } t_kind;

endpackage

FILE: rtl/fwt_if.sv
// fwt_req_if, fwt_rsp_if: valid/ready channels of the futex wait table
// depends on fwt_pkg
interface fwt_req_if;
    logic                         valid;
    logic                         ready;
    fwt_pkg::t_kind               kind;
    logic [fwt_pkg::AddrW-1:0]    wait_address;
    logic [fwt_pkg::ThreadW-1:0]  thread_id;
    logic [fwt_pkg::CountW-1:0]   wake_count;
    logic [fwt_pkg::AddrW-1:0]    new_address;

    modport source (output valid, kind, wait_address, thread_id, wake_count, new_address,
                    input ready);
    modport sink   (input valid, kind, wait_address, thread_id, wake_count, new_address,
                    output ready);
endinterface

interface fwt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         has_thread;
    logic [fwt_pkg::ThreadW-1:0]  woken_thread;
    logic                         status;
    logic                         last;

    modport source  (output valid, has_thread, woken_thread, status, last, input ready);
    modport sink    (input valid, has_thread, woken_thread, status, last, output ready);
    modport monitor (input valid, ready, has_thread, woken_thread, status, last);
endinterface

FILE: rtl/fwt_table.sv
// fwt_table: entry store of the futex wait table, one write and one read port
// registered read data; no dependencies
module fwt_table #(
    parameter  int DEPTH = 32,
    parameter  int WIDTH = 72,
    localparam int IdxW  = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic [IdxW-1:0]  i_rd_idx,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_we,
    input  logic [IdxW-1:0]  i_wr_idx,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/fwt_scan.sv
// fwt_scan: operation sequencer, walks the entry store one entry a cycle unless a held result beat stalls it
// holds the valid bits, the pending woken thread and the output register; uses fwt_pkg, fwt_req_if, fwt_rsp_if
module fwt_scan #(
    parameter  int ENTRIES = 32,
    parameter  int ThW     = 8,
    localparam int IdxW    = $clog2(ENTRIES),
    localparam int DataW   = fwt_pkg::AddrW + ThW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fwt_req_if.sink          i_req,
    fwt_rsp_if.source        o_rsp,
    output logic [IdxW-1:0]  o_rd_idx,
    input  logic [DataW-1:0] i_rd_data,
    output logic             o_we,
    output logic [IdxW-1:0]  o_wr_idx,
    output logic [DataW-1:0] o_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

    t_state                       r_state;
    fwt_pkg::t_kind               r_kind;
    logic [fwt_pkg::AddrW-1:0]    r_addr;
    logic [fwt_pkg::AddrW-1:0]    r_naddr;
    logic [ThW-1:0]               r_th;
    logic [fwt_pkg::CountW-1:0]   r_limit;
    logic [fwt_pkg::CountW-1:0]   r_nwoke;
    logic                         r_found;
    logic                         r_pend;
    logic [ThW-1:0]               r_pth;
    logic [IdxW-1:0]              r_ridx;
    logic [ENTRIES-1:0]           r_valid;
    logic                         r_ov;
    logic                         r_ohas;
    logic [fwt_pkg::ThreadW-1:0]  r_oth;
    logic                         r_ostat;
    logic                         r_olast;

    logic [fwt_pkg::AddrW-1:0]    rd_addr;
    logic [ThW-1:0]               rd_thread;
    logic                         out_free;
    logic                         wake_op;
    logic                         hit;
    logic                         th_hit;
    logic                         can_wake;
    logic                         do_wake;
    logic                         stall;
    logic                         advance;
    logic                         take_free;
    logic                         move;
    logic                         fl_push;
    logic                         out_load;

    assign rd_addr   = i_rd_data[DataW-1 -: fwt_pkg::AddrW];
    assign rd_thread = i_rd_data[ThW-1:0];

    assign out_free  = !r_ov || o_rsp.ready;
    assign wake_op   = (r_kind == fwt_pkg::KIND_WAKE) || (r_kind == fwt_pkg::KIND_REQUEUE);
    assign hit       = r_valid[r_ridx] && (rd_addr == r_addr);
    assign th_hit    = r_valid[r_ridx] && (rd_thread == r_th);
    assign can_wake  = r_nwoke < r_limit;
    assign do_wake   = (r_state == ST_SCAN) && wake_op && hit && can_wake;
    assign stall     = do_wake && r_pend && !out_free;
    assign advance   = (r_state == ST_SCAN) && !stall;
    assign take_free = (r_kind == fwt_pkg::KIND_WAIT) && !r_found && !r_valid[r_ridx];
    assign move      = (r_kind == fwt_pkg::KIND_REQUEUE) && hit && !can_wake;
    assign fl_push   = (r_kind == fwt_pkg::KIND_WAIT) || (wake_op && r_pend);
    assign out_load  = (advance && do_wake && r_pend) ||
                       ((r_state == ST_FLUSH) && fl_push && out_free);

    always_comb begin
        unique case (r_state)
            ST_SCAN:  o_rd_idx = stall ? r_ridx :
                                 (r_ridx == LastIdx) ? '0 : r_ridx + IdxW'(1);
            default:  o_rd_idx = '0;
        endcase
    end

    assign o_we      = advance && (take_free || move);
    assign o_wr_idx  = r_ridx;
    assign o_wr_data = (r_kind == fwt_pkg::KIND_WAIT) ? {r_addr, r_th} : {r_naddr, rd_thread};

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_ov;
    assign o_rsp.has_thread   = r_ohas;
    assign o_rsp.woken_thread = r_oth;
    assign o_rsp.status       = r_ostat;
    assign o_rsp.last         = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
            r_pend  <= 1'b0;
            r_nwoke <= '0;
            r_ridx  <= '0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_kind  <= i_req.kind;
                        r_addr  <= i_req.wait_address;
                        r_naddr <= i_req.new_address;
                        r_th    <= i_req.thread_id[ThW-1:0];
                        r_limit <= (i_req.wake_count > fwt_pkg::MaxResults) ?
                                   fwt_pkg::MaxResults : i_req.wake_count;
                        r_nwoke <= '0;
                        r_found <= 1'b0;
                        r_pend  <= 1'b0;
                        r_ridx  <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        if (take_free) begin
                            r_valid[r_ridx] <= 1'b1;
                            r_found         <= 1'b1;
                        end
                        if (do_wake) begin
                            r_valid[r_ridx] <= 1'b0;
                            r_nwoke         <= r_nwoke + fwt_pkg::CountW'(1);
                            r_pend          <= 1'b1;
                            r_pth           <= rd_thread;
                            if (r_pend) begin
                                // earlier thread goes out, more follow
                                r_ohas  <= 1'b1;
                                r_oth   <= fwt_pkg::ThreadW'(r_pth);
                                r_ostat <= 1'b0;
                                r_olast <= 1'b0;
                            end
                        end
                        if ((r_kind == fwt_pkg::KIND_CLEAR) && th_hit) begin
                            r_valid[r_ridx] <= 1'b0;
                        end
                        if (r_ridx == LastIdx) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_ridx <= r_ridx + IdxW'(1);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!fl_push) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_olast <= 1'b1;
                        if (r_kind == fwt_pkg::KIND_WAIT) begin
                            r_ohas  <= 1'b0;
                            r_oth   <= '0;
                            r_ostat <= !r_found;
                        end else begin
                            r_ohas  <= 1'b1;
                            r_oth   <= fwt_pkg::ThreadW'(r_pth);
                            r_ostat <= 1'b0;
                        end
                        r_pend  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/futex_wait_table_core.sv
// futex_wait_table_core: table of futex waiters with wait, wake, requeue and clear
// depends on fwt_pkg, fwt_req_if, fwt_rsp_if, fwt_table, fwt_scan
// Every operation walks all ENTRIES table entries in index order, one entry per cycle
// through the single read port of the entry store while no result beat is held back,
// so an item goes through accept, scan and flush, and waits while the result side
// holds ready low and a beat waits to go out. A new item is taken once the previous one
// has left any final beat in the output register, where it may still wait to be taken.
// Wait gives one beat (status 1 when the table is full), wake and requeue one beat per
// woken thread with last on the final one, clear gives none. No clearing pass follows
// reset: the valid bits are flip-flops cleared at once.
module futex_wait_table_core #(
    parameter int ENTRIES     = 32,
    parameter int THREAD_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fwt_req_if.sink   i_req,
    fwt_rsp_if.source o_rsp
);

    localparam int ThW   = (THREAD_BITS < fwt_pkg::ThreadW) ? THREAD_BITS : fwt_pkg::ThreadW;
    localparam int IdxW  = $clog2(ENTRIES);
    localparam int DataW = fwt_pkg::AddrW + ThW;

    logic [IdxW-1:0]  rd_idx;
    logic [DataW-1:0] rd_data;
    logic             we;
    logic [IdxW-1:0]  wr_idx;
    logic [DataW-1:0] wr_data;

    fwt_table #(
        .DEPTH (ENTRIES),
        .WIDTH (DataW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data),
        .i_we      (we),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data)
    );

    fwt_scan #(
        .ENTRIES (ENTRIES),
        .ThW     (ThW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_rd_idx  (rd_idx),
        .i_rd_data (rd_data),
        .o_we      (we),
        .o_wr_idx  (wr_idx),
        .o_wr_data (wr_data)
    );

endmodule

FILE: rtl/fwt_checker.sv
// fwt_checker: port level checks on the result channel of futex_wait_table_core
// depends on fwt_pkg; bound to the top level below
module fwt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic                        i_has_thread,
    input logic [fwt_pkg::ThreadW-1:0] i_woken_thread,
    input logic                        i_status,
    input logic                        i_last
);

    // no beat comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

    // a woken thread always carries ok status
    a_woken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_has_thread) |-> !i_status)
        else $error("woken thread with full status");

    // a wait beat stands alone and names no thread
    a_wait_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_has_thread) |-> (i_last && (i_woken_thread == '0)))
        else $error("wait beat malformed");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_has_thread) && $stable(i_woken_thread)
             && $stable(i_status) && $stable(i_last)))
        else $error("stalled beat changed");

endmodule

bind futex_wait_table_core fwt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_has_thread   (o_rsp.has_thread),
    .i_woken_thread (o_rsp.woken_thread),
    .i_status       (o_rsp.status),
    .i_last         (o_rsp.last)
);
